FILE: rtl/priority_tx_queue_frame_evict_unit_defines.svh
// assertion macros shared by the rtl files
// depends on nothing; each file that asserts includes it
`ifndef PRIORITY_TX_QUEUE_FRAME_EVICT_UNIT_DEFINES_SVH
`define PRIORITY_TX_QUEUE_FRAME_EVICT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PTQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTQ_ASSERT_IMP(label, ante, cons, msg)
`define PTQ_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/ptqfe_pkg.sv
// types and constants of the strict priority transmit queue
// used by priority_tx_queue_frame_evict_unit; depends on nothing
package ptqfe_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned ClassCountDef = 4;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED = 3'd0,
    STS_INVALID  = 3'd1,
    STS_FULL     = 3'd2,
    STS_SERVED   = 3'd3,
    STS_EMPTY    = 3'd4,
    STS_PEEKED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_MAGIC     = 3'd0,
    CFG_FRAG_MASK = 3'd1,
    CFG_LAST_MASK = 3'd2,
    CFG_HDR_MIN   = 3'd3,
    CFG_MAX_LEN   = 3'd4,
    CFG_DROP_OLD  = 3'd5,
    CFG_BULK      = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EVICT,
    ST_WRITE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  priority_class;
    logic [7:0]  reliability_tag;
    logic [15:0] frame_handle;
    logic [15:0] frame_len;
    logic [7:0]  hdr_magic;
    logic [7:0]  hdr_flags;
    logic [15:0] hdr_seq;
    logic [47:0] dest_mac_in;
    logic        dest_mac_valid;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  served_class;
    logic [15:0] out_handle;
    logic [15:0] out_len;
    logic [7:0]  out_reliability;
    logic [47:0] out_dest_mac;
    logic        out_dest_valid;
    logic [6:0]  evicted_slots;
    logic [6:0]  class_depth;
    logic [8:0]  pending_total;
    logic [31:0] class_drops;
  } out_word_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] len;
    logic [7:0]  rel;
    logic        frag;
    logic        last;
    logic [15:0] seq;
    logic [47:0] dmac;
    logic        dvalid;
  } slot_t;

endpackage

FILE: rtl/priority_tx_queue_frame_evict_unit.sv
// Strict priority transmit queue: one descriptor ring per class in a shared slot memory,
// with frame-atomic eviction of fragment runs. An item passes accept, decode, and a
// slot memory read or write that also loads the result. An invalid request, a dequeue or
// peek that finds nothing, and a full reject-newest enqueue load their result in decode.
// An enqueue into a full drop-oldest ring first evicts descriptors, as the eviction walks
// the fragment run one slot memory read per cycle. A walk that stops at a slot outside the
// run keeps that slot. A partly sent tail frame is rejected at the first eviction read. The
// next word is taken while a result waits at the output. Decode then holds until that
// result leaves. Depends on ptqfe_pkg and the defines header.
`include "priority_tx_queue_frame_evict_unit_defines.svh"

module priority_tx_queue_frame_evict_unit import ptqfe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned CLASS_COUNT = ClassCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CLASS_COUNT);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(CLASS_COUNT * QUEUE_DEPTH + 1);
  localparam int unsigned AW = CW + SW;
  localparam int unsigned MemDepth = CLASS_COUNT << SW;

  // configuration
  logic [7:0]  magic_q, frag_mask_q, last_mask_q, hdr_min_q;
  logic [15:0] max_len_q;
  logic [3:0]  drop_old_q;
  logic [1:0]  bulk_q;

  // per class ring state
  logic [SW-1:0] head_q [CLASS_COUNT];
  logic [SW-1:0] head_d [CLASS_COUNT];
  logic [SW-1:0] tail_q [CLASS_COUNT];
  logic [SW-1:0] tail_d [CLASS_COUNT];
  logic [NW-1:0] cnt_q  [CLASS_COUNT];
  logic [NW-1:0] cnt_d  [CLASS_COUNT];
  logic          infl_q [CLASS_COUNT];
  logic          infl_d [CLASS_COUNT];
  logic [15:0]   iseq_q [CLASS_COUNT];
  logic [15:0]   iseq_d [CLASS_COUNT];
  logic [31:0]   drops_q [CLASS_COUNT];
  logic [31:0]   drops_d [CLASS_COUNT];
  logic [PW-1:0] pend_q, pend_d;

  state_e        state_q, state_d;
  in_word_t      req_q, req_d;
  logic [CW-1:0] cls_q, cls_d;
  logic          first_q, first_d;
  logic          run_frag_q, run_frag_d;
  logic [15:0]   run_seq_q, run_seq_d;
  logic [NW-1:0] evicted_q, evicted_d;
  out_word_t     out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // slot memory
  slot_t         mem [MemDepth];
  slot_t         rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  slot_t         mem_wdata;

  logic          in_acc;
  logic [CW-1:0] cls_enq, deq_cls;
  logic          deq_found;
  logic [1:0]    bulk_sat;
  logic [7:0]    mask8;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign mask8       = 8'(drop_old_q);

  assign bulk_sat = (4'(bulk_q) >= 4'(CLASS_COUNT)) ? 2'(CLASS_COUNT - 1) : bulk_q;
  assign cls_enq  = (req_q.priority_class >= 8'(CLASS_COUNT)) ? CW'(bulk_sat)
                                                              : CW'(req_q.priority_class);

  always_comb begin
    deq_found = 1'b0;
    deq_cls   = '0;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        deq_found = 1'b1;
        deq_cls   = CW'(i);
      end
    end
  end

  function automatic logic [SW-1:0] next_idx(input logic [SW-1:0] i);
    return (i == SW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    logic          put_cls, put_slot, do_load;
    logic [CW-1:0] c;
    status_e       sts;
    slot_t         d;
    logic          evict_mode, run, matches_run;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; infl_d = infl_q;
    iseq_d = iseq_q; drops_d = drops_q; pend_d = pend_q;
    state_d = state_q; req_d = req_q; cls_d = cls_q; first_d = first_q;
    run_frag_d = run_frag_q; run_seq_d = run_seq_q; evicted_d = evicted_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_re = 1'b0; mem_raddr = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0;
    put_cls = 1'b0; put_slot = 1'b0; do_load = 1'b0;
    c = cls_q; sts = STS_INVALID; d = rdata_q;
    evict_mode = mask8[3'(cls_enq)];
    run = 1'b0; matches_run = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d   = in_data_i;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        // hold until the output register is free; nothing else can fill it
        if (!(out_valid_q && out_stall_i)) begin
          case (req_q.opcode)
            OP_ENQ: begin
              c = cls_enq;
              cls_d = cls_enq;
              if (req_q.frame_len == '0 || req_q.frame_len > max_len_q) begin
                sts = STS_INVALID; put_cls = 1'b1; do_load = 1'b1;
              end else if (cnt_q[c] == NW'(QUEUE_DEPTH)) begin
                if (!evict_mode) begin
                  drops_d[c] = drops_q[c] + 1'b1;
                  sts = STS_FULL; put_cls = 1'b1; do_load = 1'b1;
                end else begin
                  mem_re = 1'b1; mem_raddr = {c, tail_q[c]};
                  first_d = 1'b1; evicted_d = '0;
                  state_d = ST_EVICT;
                end
              end else begin
                evicted_d = '0;
                state_d = ST_WRITE;
              end
            end
            OP_DEQ: begin
              if (!deq_found) begin
                sts = STS_EMPTY; do_load = 1'b1;
              end else begin
                cls_d = deq_cls;
                mem_re = 1'b1; mem_raddr = {deq_cls, tail_q[deq_cls]};
                state_d = ST_READ;
              end
            end
            OP_PEEK: begin
              if (req_q.priority_class >= 8'(CLASS_COUNT)) begin
                sts = STS_INVALID; do_load = 1'b1;
              end else begin
                c = CW'(req_q.priority_class);
                cls_d = c;
                if (cnt_q[c] == '0) begin
                  sts = STS_EMPTY; put_cls = 1'b1; do_load = 1'b1;
                end else begin
                  mem_re = 1'b1; mem_raddr = {c, tail_q[c]};
                  state_d = ST_READ;
                end
              end
            end
            default: begin
              sts = STS_INVALID; do_load = 1'b1;
            end
          endcase
        end
      end
      ST_EVICT: begin
        run = first_q ? d.frag : run_frag_q;
        matches_run = run_frag_q && d.frag && (d.seq == run_seq_q);
        if (first_q && infl_q[c] && d.frag && d.seq == iseq_q[c]) begin
          // tail frame is partly sent
          drops_d[c] = drops_q[c] + 1'b1;
          sts = STS_FULL; put_cls = 1'b1; do_load = 1'b1;
        end else if (first_q || matches_run) begin
          if (first_q) begin
            run_frag_d = d.frag;
            run_seq_d  = d.seq;
          end
          first_d    = 1'b0;
          tail_d[c]  = next_idx(tail_q[c]);
          cnt_d[c]   = cnt_q[c] - 1'b1;
          drops_d[c] = drops_q[c] + 1'b1;
          pend_d     = pend_q - 1'b1;
          evicted_d  = evicted_q + 1'b1;
          if (run && cnt_q[c] != NW'(1)) begin
            mem_re = 1'b1; mem_raddr = {c, tail_d[c]};
          end else begin
            state_d = ST_WRITE;
          end
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = {c, head_q[c]};
        mem_wdata.handle = req_q.frame_handle;
        mem_wdata.len    = req_q.frame_len;
        mem_wdata.rel    = req_q.reliability_tag;
        mem_wdata.frag   = (req_q.frame_len >= 16'(hdr_min_q)) &&
                           (req_q.hdr_magic == magic_q) &&
                           ((req_q.hdr_flags & frag_mask_q) != '0);
        mem_wdata.seq    = mem_wdata.frag ? req_q.hdr_seq : '0;
        mem_wdata.last   = mem_wdata.frag ? ((req_q.hdr_flags & last_mask_q) != '0) : 1'b1;
        mem_wdata.dvalid = req_q.dest_mac_valid;
        mem_wdata.dmac   = req_q.dest_mac_valid ? req_q.dest_mac_in : '0;
        head_d[c] = next_idx(head_q[c]);
        cnt_d[c]  = cnt_q[c] + 1'b1;
        pend_d    = pend_q + 1'b1;
        sts = STS_ACCEPTED; put_cls = 1'b1; do_load = 1'b1;
      end
      ST_READ: begin
        if (req_q.opcode == OP_DEQ) begin
          tail_d[c] = next_idx(tail_q[c]);
          cnt_d[c]  = cnt_q[c] - 1'b1;
          pend_d    = pend_q - 1'b1;
          if (d.frag) begin
            if (!d.last) begin
              infl_d[c] = 1'b1;
              iseq_d[c] = d.seq;
            end else if (infl_q[c] && iseq_q[c] == d.seq) begin
              infl_d[c] = 1'b0;
            end
          end
          sts = STS_SERVED;
        end else begin
          sts = STS_PEEKED;
        end
        put_cls = 1'b1; put_slot = 1'b1; do_load = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_load) begin
      out_d = '0;
      out_d.status        = sts;
      out_d.pending_total = 9'(pend_d);
      if (sts == STS_ACCEPTED) out_d.evicted_slots = 7'(evicted_d);
      if (put_cls) begin
        out_d.served_class = 2'(c);
        out_d.class_depth  = 7'(cnt_d[c]);
        out_d.class_drops  = drops_d[c];
      end
      if (put_slot) begin
        out_d.out_handle      = d.handle;
        out_d.out_len         = d.len;
        out_d.out_reliability = d.rel;
        out_d.out_dest_mac    = d.dmac;
        out_d.out_dest_valid  = d.dvalid;
      end
      out_valid_d = 1'b1;
      state_d     = ST_IDLE;
    end
  end

  // write then read on later cycles: a read never overlaps the write of the same item
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    run_frag_q <= run_frag_d;
    run_seq_q  <= run_seq_d;
    evicted_q  <= evicted_d;
    out_q      <= out_d;
    cls_q      <= cls_d;
    first_q    <= first_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        cnt_q[i]   <= '0;
        infl_q[i]  <= 1'b0;
        iseq_q[i]  <= '0;
        drops_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      infl_q  <= infl_d;
      iseq_q  <= iseq_d;
      drops_q <= drops_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q     <= 8'd0;
      frag_mask_q <= 8'd1;
      last_mask_q <= 8'd2;
      hdr_min_q   <= 8'd8;
      max_len_q   <= 16'd2048;
      drop_old_q  <= 4'd12;
      bulk_q      <= 2'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAGIC:     magic_q     <= cfg_data_i[7:0];
        CFG_FRAG_MASK: frag_mask_q <= cfg_data_i[7:0];
        CFG_LAST_MASK: last_mask_q <= cfg_data_i[7:0];
        CFG_HDR_MIN:   hdr_min_q   <= cfg_data_i[7:0];
        CFG_MAX_LEN:   max_len_q   <= cfg_data_i;
        CFG_DROP_OLD:  drop_old_q  <= cfg_data_i[3:0];
        CFG_BULK:      bulk_q      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  `PTQ_ASSERT_NXT(a_accept_decode, in_valid_i && !in_stall_o, state_q == ST_DECODE, "accepted word did not reach decode")
  `PTQ_ASSERT_IMP(a_result_idle, $rose(out_valid_o), state_q == ST_IDLE, "result shown while busy")
  `PTQ_ASSERT_IMP(a_evict_nonempty, state_q == ST_EVICT, cnt_q[cls_q] != '0, "eviction walk on empty ring")
  `PTQ_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= PW'(CLASS_COUNT * QUEUE_DEPTH), "pending count overflow")

endmodule
